>>> src/sprk_pkg.sv
package sprk_pkg;

    localparam int OP_W            = 2;
    localparam int KEY_IN_W        = 32;
    localparam int ID_W            = 10;
    localparam int PAIR_W          = 2 * ID_W;
    localparam int POS_W           = 10;
    localparam int STATUS_W        = 2;
    localparam int TOTAL_W         = 11;
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_WIDTH   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REKEY  = 2'd1,
        OP_POP    = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        RD_NONE   = 3'd0,
        RD_LAST   = 3'd1,
        RD_POS    = 3'd2,
        RD_POSINC = 3'd3,
        RD_PREV   = 3'd4,
        RD_NEXT   = 3'd5
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_UP   = 2'd1,
        WR_DOWN = 2'd2,
        WR_NEW  = 2'd3
    } t_wr_sel;

    typedef enum logic [2:0] {
        IDX_HOLD   = 3'd0,
        IDX_LAST   = 3'd1,
        IDX_ZERO   = 3'd2,
        IDX_DEC    = 3'd3,
        IDX_INC    = 3'd4,
        IDX_POSINC = 3'd5
    } t_idx_op;

    typedef enum logic [1:0] {
        FILL_HOLD = 2'd0,
        FILL_INC  = 2'd1,
        FILL_DEC  = 2'd2
    } t_fill_op;

    typedef enum logic [1:0] {
        RES_HOLD  = 2'd0,
        RES_ERR   = 2'd1,
        RES_PLACE = 2'd2,
        RES_TAKE  = 2'd3
    } t_res_op;

    typedef struct packed {
        logic     load;
        t_rd_sel  rd_sel;
        t_wr_sel  wr_sel;
        t_idx_op  idx_op;
        t_fill_op fill_op;
        t_res_op  res_op;
        t_status  err_code;
        logic     to_insert;
        logic     publish;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic fill_zero;
        logic pos_bad;
        logic pos_last;
        logic greater;
        logic idx_zero;
        logic idx_last;
    } t_stat;

endpackage

>>> src/sprk_if.sv
interface sprk_in_if import sprk_pkg::*;;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [KEY_IN_W-1:0] key;
    logic [ID_W-1:0]     first_id;
    logic [ID_W-1:0]     second_id;
    logic [POS_W-1:0]    position;

    modport source (
        output valid, op, key, first_id, second_id, position,
        input  ready
    );

    modport sink (
        input  valid, op, key, first_id, second_id, position,
        output ready
    );
endinterface

interface sprk_out_if import sprk_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_IN_W-1:0] out_key;
    logic [ID_W-1:0]     out_first_id;
    logic [ID_W-1:0]     out_second_id;
    logic [POS_W-1:0]    final_position;
    logic [TOTAL_W-1:0]  entry_total;

    modport source (
        output valid, status, out_key, out_first_id, out_second_id,
               final_position, entry_total,
        input  ready
    );

    modport sink (
        input  valid, status, out_key, out_first_id, out_second_id,
               final_position, entry_total,
        output ready
    );
endinterface

>>> src/sprk_datapath.sv
module sprk_datapath import sprk_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [OP_W-1:0]     i_op,
    input  logic [KEY_IN_W-1:0] i_key,
    input  logic [ID_W-1:0]     i_first_id,
    input  logic [ID_W-1:0]     i_second_id,
    input  logic [POS_W-1:0]    i_position,
    output logic [STATUS_W-1:0] o_status,
    output logic [KEY_IN_W-1:0] o_out_key,
    output logic [ID_W-1:0]     o_out_first_id,
    output logic [ID_W-1:0]     o_out_second_id,
    output logic [POS_W-1:0]    o_final_position,
    output logic [TOTAL_W-1:0]  o_entry_total
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int PCW = (CW > POS_W) ? CW : POS_W;
    localparam int FW  = (AW > POS_W) ? AW : POS_W;
    localparam int TW  = (CW > TOTAL_W) ? CW : TOTAL_W;
    localparam int EW  = KEY_WIDTH + PAIR_W;

    logic [EW-1:0]        mem [TABLE_DEPTH];
    logic [EW-1:0]        r_rd_data;

    t_op                  r_op;
    logic [KEY_WIDTH-1:0] r_key;
    logic [PAIR_W-1:0]    r_pair;
    logic [POS_W-1:0]     r_pos;
    logic [CW-1:0]        r_fill;
    logic [AW-1:0]        r_idx;

    t_status              r_res_status;
    logic [KEY_WIDTH-1:0] r_res_key;
    logic [PAIR_W-1:0]    r_res_pair;
    logic [AW-1:0]        r_res_fpos;

    logic [STATUS_W-1:0]  r_out_status;
    logic [KEY_IN_W-1:0]  r_out_key;
    logic [PAIR_W-1:0]    r_out_pair;
    logic [POS_W-1:0]     r_out_fpos;
    logic [TOTAL_W-1:0]   r_out_total;

    logic [63:0]          key_in_wide;
    logic [63:0]          res_key_wide;
    logic [KEY_WIDTH-1:0] key_in;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [PAIR_W-1:0]    rd_pair;
    logic [CW-1:0]        fill_m1;
    logic [PCW-1:0]       pos_w;
    logic [PCW-1:0]       fill_pw;
    logic [PCW-1:0]       pos_p1;
    logic [CW:0]          idx_p1;
    logic [FW-1:0]        fpos_w;
    logic [TW-1:0]        total_w;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;

    assign key_in_wide  = 64'(i_key);
    assign key_in       = key_in_wide[KEY_WIDTH-1:0];
    assign res_key_wide = 64'(r_res_key);
    assign rd_key       = r_rd_data[EW-1:PAIR_W];
    assign rd_pair      = r_rd_data[PAIR_W-1:0];
    assign fill_m1      = r_fill - CW'(1);
    assign pos_w        = PCW'(r_pos);
    assign fill_pw      = PCW'(r_fill);
    assign pos_p1       = pos_w + PCW'(1);
    assign idx_p1       = (CW + 1)'(r_idx) + (CW + 1)'(1);
    assign fpos_w       = FW'(r_res_fpos);
    assign total_w      = TW'(r_fill);

    assign o_stat.op        = r_op;
    assign o_stat.full      = (r_fill == CW'(TABLE_DEPTH));
    assign o_stat.fill_zero = (r_fill == '0);
    assign o_stat.pos_bad   = (pos_w >= fill_pw);
    assign o_stat.pos_last  = (pos_p1 == fill_pw);
    assign o_stat.greater   = (rd_key > r_key);
    assign o_stat.idx_zero  = (r_idx == '0);
    assign o_stat.idx_last  = (idx_p1 == (CW + 1)'(r_fill));

    always_comb begin
        rd_en = (i_cmd.rd_sel != RD_NONE);
        case (i_cmd.rd_sel)
            RD_LAST:   rd_addr = fill_m1[AW-1:0];
            RD_POS:    rd_addr = pos_w[AW-1:0];
            RD_POSINC: rd_addr = pos_p1[AW-1:0];
            RD_PREV:   rd_addr = r_idx - AW'(1);
            RD_NEXT:   rd_addr = r_idx + AW'(1);
            default:   rd_addr = '0;
        endcase
    end

    always_comb begin
        wr_en = (i_cmd.wr_sel != WR_NONE);
        case (i_cmd.wr_sel)
            WR_UP: begin
                wr_addr = r_idx + AW'(1);
                wr_data = r_rd_data;
            end
            WR_DOWN: begin
                wr_addr = r_idx - AW'(1);
                wr_data = r_rd_data;
            end
            WR_NEW: begin
                wr_addr = r_idx;
                wr_data = {r_key, r_pair};
            end
            default: begin
                wr_addr = '0;
                wr_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            case (i_cmd.fill_op)
                FILL_INC: r_fill <= r_fill + CW'(1);
                FILL_DEC: r_fill <= fill_m1;
                default:  r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_key  <= key_in;
            r_pair <= {i_second_id, i_first_id};
            r_pos  <= i_position;
        end else if (i_cmd.to_insert) begin
            r_op <= OP_INSERT;
        end

        case (i_cmd.idx_op)
            IDX_LAST:   r_idx <= fill_m1[AW-1:0];
            IDX_ZERO:   r_idx <= '0;
            IDX_DEC:    r_idx <= r_idx - AW'(1);
            IDX_INC:    r_idx <= r_idx + AW'(1);
            IDX_POSINC: r_idx <= pos_p1[AW-1:0];
            default:    r_idx <= r_idx;
        endcase

        case (i_cmd.res_op)
            RES_ERR: begin
                r_res_status <= i_cmd.err_code;
                r_res_key    <= '0;
                r_res_pair   <= '0;
                r_res_fpos   <= '0;
            end
            RES_PLACE: begin
                r_res_status <= ST_OK;
                r_res_key    <= r_key;
                r_res_pair   <= r_pair;
                r_res_fpos   <= r_idx;
            end
            RES_TAKE: begin
                r_res_status <= ST_OK;
                r_res_key    <= rd_key;
                r_res_pair   <= rd_pair;
                r_res_fpos   <= '0;
                r_pair       <= rd_pair;
            end
            default: begin
                r_res_status <= r_res_status;
            end
        endcase

        if (i_cmd.publish) begin
            r_out_status <= r_res_status;
            r_out_key    <= res_key_wide[KEY_IN_W-1:0];
            r_out_pair   <= r_res_pair;
            r_out_fpos   <= fpos_w[POS_W-1:0];
            r_out_total  <= total_w[TOTAL_W-1:0];
        end
    end

    assign o_status         = r_out_status;
    assign o_out_key        = r_out_key;
    assign o_out_first_id   = r_out_pair[ID_W-1:0];
    assign o_out_second_id  = r_out_pair[PAIR_W-1:ID_W];
    assign o_final_position = r_out_fpos;
    assign o_entry_total    = r_out_total;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_fill != $past(r_fill))) |->
        ((r_fill == $past(r_fill) + CW'(1)) || (r_fill == $past(r_fill) - CW'(1))))
        else $error("entry count moved by more than one");
    a_grow_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fill_op == FILL_INC) |-> (i_cmd.wr_sel == WR_NEW))
        else $error("table grew without placing an entry");
`endif

endmodule

>>> src/sprk_ctrl.sv
module sprk_ctrl import sprk_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_SCMP   = 8'b0000_0100,
        S_PLACE  = 8'b0000_1000,
        S_POPD   = 8'b0001_0000,
        S_RMD    = 8'b0010_0000,
        S_SHL    = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        if (i_stat.full) begin
                            cmd.res_op   = RES_ERR;
                            cmd.err_code = ST_FULL;
                            n_state      = S_FINISH;
                        end else if (i_stat.fill_zero) begin
                            cmd.idx_op = IDX_ZERO;
                            n_state    = S_PLACE;
                        end else begin
                            cmd.rd_sel = RD_LAST;
                            cmd.idx_op = IDX_LAST;
                            n_state    = S_SCMP;
                        end
                    end
                    OP_POP: begin
                        if (i_stat.fill_zero) begin
                            cmd.res_op   = RES_ERR;
                            cmd.err_code = ST_EMPTY;
                            n_state      = S_FINISH;
                        end else begin
                            cmd.rd_sel = RD_LAST;
                            n_state    = S_POPD;
                        end
                    end
                    OP_REKEY, OP_REMOVE: begin
                        if (i_stat.pos_bad) begin
                            cmd.res_op   = RES_ERR;
                            cmd.err_code = ST_RANGE;
                            n_state      = S_FINISH;
                        end else begin
                            cmd.rd_sel = RD_POS;
                            n_state    = S_RMD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCMP: begin
                if (i_stat.greater) begin
                    cmd.idx_op = IDX_INC;
                    n_state    = S_PLACE;
                end else if (i_stat.idx_zero) begin
                    cmd.wr_sel = WR_UP;
                    n_state    = S_PLACE;
                end else begin
                    cmd.wr_sel = WR_UP;
                    cmd.rd_sel = RD_PREV;
                    cmd.idx_op = IDX_DEC;
                end
            end
            S_PLACE: begin
                cmd.wr_sel  = WR_NEW;
                cmd.fill_op = FILL_INC;
                cmd.res_op  = RES_PLACE;
                n_state     = S_FINISH;
            end
            S_POPD: begin
                cmd.res_op  = RES_TAKE;
                cmd.fill_op = FILL_DEC;
                n_state     = S_FINISH;
            end
            S_RMD: begin
                cmd.res_op = RES_TAKE;
                if (i_stat.pos_last) begin
                    cmd.fill_op = FILL_DEC;
                    if (i_stat.op == OP_REKEY) begin
                        cmd.to_insert = 1'b1;
                        n_state       = S_DECODE;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    cmd.rd_sel = RD_POSINC;
                    cmd.idx_op = IDX_POSINC;
                    n_state    = S_SHL;
                end
            end
            S_SHL: begin
                cmd.wr_sel = WR_DOWN;
                if (i_stat.idx_last) begin
                    cmd.fill_op = FILL_DEC;
                    if (i_stat.op == OP_REKEY) begin
                        cmd.to_insert = 1'b1;
                        n_state       = S_DECODE;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    cmd.rd_sel = RD_NEXT;
                    cmd.idx_op = IDX_INC;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.publish = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a beat not yet taken");
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted beat not decoded");
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result raised outside finish");
`endif

endmodule

>>> src/sorted_pair_list_rekey.sv
// Sorted table of point-pair entries (key plus two ids), held in descending key
// order in a single-port-write, single-port-read memory; a new or rekeyed entry
// lands in front of every entry with an equal or smaller key. One operation is
// worked at a time and every operation returns one result beat. The memory moves
// one entry per cycle when entries have to shift: insert shifts the entries from
// final_position to the end up by one, remove shifts those behind position down
// by one, and rekey is a remove followed by an insert. A new item is taken while
// an earlier result still waits at the output register; nothing needs clearing
// after reset.
module sorted_pair_list_rekey import sprk_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
    input logic        i_clk,
    input logic        i_rst_n,
    sprk_in_if.sink    i_in,
    sprk_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    sprk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sprk_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_op             (i_in.op),
        .i_key            (i_in.key),
        .i_first_id       (i_in.first_id),
        .i_second_id      (i_in.second_id),
        .i_position       (i_in.position),
        .o_status         (o_out.status),
        .o_out_key        (o_out.out_key),
        .o_out_first_id   (o_out.out_first_id),
        .o_out_second_id  (o_out.out_second_id),
        .o_final_position (o_out.final_position),
        .o_entry_total    (o_out.entry_total)
    );

endmodule
